@@ rtl/core/frnq_pkg.sv @@
`default_nettype none
package frnq_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int DIM_DEF        = 8;

	localparam int COORD_W   = 16;
	localparam int RADIUS_W  = 16;
	localparam int REF_W     = 10;
	localparam int IDX_OUT_W = 10;
	localparam int DIST_W    = 40;
	localparam int R2_W      = 2 * RADIUS_W;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF    = 1'b1;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd9830;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SKIP_RD,
		ST_SKIP_CHK,
		ST_PIV,
		ST_QRY,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RES,
		ST_EMIT_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic fill;
		logic cur_inc;
		logic issue_piv;
		logic issue_qry;
		logic scan_issue;
		logic emit_res;
		logic emit_done;
	} ctl_t;

	typedef struct packed {
		logic is_fetch;
		logic load_fill;
		logic fill_last;
		logic cur_end;
		logic flag;
		logic ld_last;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/core/fixed_radius_neighbor_query.sv @@
// Fixed-radius neighbor query. A load transfer carries one coordinate; when the final
// coordinate of a point is given before the DIM-th, the block zeros the rest of that
// point before it takes the next transfer. A fetch skips the non-query points before
// the next query, then loads the pivot and query vectors and sweeps all N*DIM stored
// coordinates, where N is the number of stored points (8192 at full size); the
// coordinate memory yields one coordinate per cycle. Results wait in an output
// register; loads are taken while a result waits, a fetch finishes once it is taken.
`default_nettype none
module fixed_radius_neighbor_query #(
	parameter int MAX_POINTS = frnq_pkg::MAX_POINTS_DEF,
	parameter int DIM        = frnq_pkg::DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [frnq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [frnq_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                cmd,
	input  wire logic                                is_query,
	input  wire logic signed [frnq_pkg::COORD_W-1:0] coord,
	input  wire logic                                coord_last,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [frnq_pkg::IDX_OUT_W-1:0]      query_index,
	output      logic [frnq_pkg::IDX_OUT_W-1:0]      neighbor_index,
	output      logic                                has_neighbor,
	output      logic                                last_of_query,
	output      logic                                all_done
);

	frnq_pkg::ctl_t ctl;
	frnq_pkg::sts_t sts;

	frnq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	frnq_dp #(.MAX_POINTS(MAX_POINTS), .DIM(DIM)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.is_query       (is_query),
		.coord          (coord),
		.coord_last     (coord_last),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.query_index    (query_index),
		.neighbor_index (neighbor_index),
		.has_neighbor   (has_neighbor),
		.last_of_query  (last_of_query),
		.all_done       (all_done)
	);

endmodule
`default_nettype wire

@@ rtl/core/frnq_ram.sv @@
`default_nettype none
module frnq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/frnq_ctrl.sv @@
`default_nettype none
module frnq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire frnq_pkg::sts_t sts,
	output      frnq_pkg::ctl_t ctl
);

	frnq_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frnq_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			frnq_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.is_fetch) begin
						state_n = frnq_pkg::ST_SKIP_RD;
					end else if (sts.load_fill) begin
						state_n = frnq_pkg::ST_FILL;
					end
				end
			end
			frnq_pkg::ST_FILL: begin
				if (sts.fill_last) state_n = frnq_pkg::ST_IDLE;
			end
			frnq_pkg::ST_SKIP_RD: begin
				state_n = sts.cur_end ? frnq_pkg::ST_EMIT_DONE : frnq_pkg::ST_SKIP_CHK;
			end
			frnq_pkg::ST_SKIP_CHK: begin
				state_n = sts.flag ? frnq_pkg::ST_PIV : frnq_pkg::ST_SKIP_RD;
			end
			frnq_pkg::ST_PIV: begin
				if (sts.ld_last) state_n = frnq_pkg::ST_QRY;
			end
			frnq_pkg::ST_QRY: begin
				if (sts.ld_last) state_n = frnq_pkg::ST_SCAN;
			end
			frnq_pkg::ST_SCAN: begin
				if (sts.scan_last) state_n = frnq_pkg::ST_DRAIN;
			end
			frnq_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) state_n = frnq_pkg::ST_EMIT_RES;
			end
			frnq_pkg::ST_EMIT_RES, frnq_pkg::ST_EMIT_DONE: begin
				if (sts.out_free) state_n = frnq_pkg::ST_IDLE;
			end
			default: state_n = frnq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			frnq_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
			end
			frnq_pkg::ST_FILL:      ctl.fill       = 1'b1;
			frnq_pkg::ST_SKIP_RD:   ;
			frnq_pkg::ST_SKIP_CHK:  ctl.cur_inc    = !sts.flag;
			frnq_pkg::ST_PIV:       ctl.issue_piv  = 1'b1;
			frnq_pkg::ST_QRY:       ctl.issue_qry  = 1'b1;
			frnq_pkg::ST_SCAN:      ctl.scan_issue = 1'b1;
			frnq_pkg::ST_DRAIN:     ;
			frnq_pkg::ST_EMIT_RES:  ctl.emit_res   = 1'b1;
			frnq_pkg::ST_EMIT_DONE: ctl.emit_done  = 1'b1;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/frnq_dp.sv @@
`default_nettype none
module frnq_dp #(
	parameter int MAX_POINTS = frnq_pkg::MAX_POINTS_DEF,
	parameter int DIM        = frnq_pkg::DIM_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire frnq_pkg::ctl_t                       ctl,
	output      frnq_pkg::sts_t                       sts,
	input  wire logic                                 cfg_we,
	input  wire logic [frnq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [frnq_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 cmd,
	input  wire logic                                 is_query,
	input  wire logic signed [frnq_pkg::COORD_W-1:0]  coord,
	input  wire logic                                 coord_last,
	input  wire logic                                 out_ready,
	output      logic                                 out_valid,
	output      logic [frnq_pkg::IDX_OUT_W-1:0]       query_index,
	output      logic [frnq_pkg::IDX_OUT_W-1:0]       neighbor_index,
	output      logic                                 has_neighbor,
	output      logic                                 last_of_query,
	output      logic                                 all_done
);

	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int PW    = $clog2(DIM + 1);
	localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DEPTH = MAX_POINTS * DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(DEPTH + 1);
	localparam int DW    = frnq_pkg::DIST_W;
	localparam int KEY_W = DW + IW;
	localparam int CO_W  = frnq_pkg::COORD_W;

	// configuration
	logic [frnq_pkg::RADIUS_W-1:0] radius_q;
	logic [frnq_pkg::REF_W-1:0]    ref_q;
	logic [frnq_pkg::R2_W-1:0]     r2_q;
	logic                          piv_zero_q;

	// load side
	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_q;
	logic [BW-1:0] base_q;
	logic          lq_q;
	logic          full, load_acc, pos_lt, finalize;
	logic [PW-1:0] pos_n;
	logic [BW-1:0] wsum;

	// query side
	logic [CW-1:0]    cur_q;
	logic [KEY_W-1:0] prev_q;
	logic             started_q;

	// memories
	logic            c_we, f_we, f_wdata, f_rdata;
	logic [AW-1:0]   c_waddr, c_raddr;
	logic [CO_W-1:0] c_wdata, c_rdata;

	// vector load
	logic signed [CO_W-1:0] piv_q [DIM];
	logic signed [CO_W-1:0] qc_q [DIM];
	logic [KW-1:0]          ld_k_q, ldk_s1;
	logic                   ldv_s1, ldt_s1, ld_last;
	logic [31:0]            pb, qb;

	// scan pipeline
	logic [AW-1:0]       sc_addr_q;
	logic [IW-1:0]       sc_j_q, j_s1, j_s2, j_s3, j_s4;
	logic [KW-1:0]       sc_k_q, k_s1;
	logic                k_last, scan_last;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic                first_s1, first_s2, first_s3;
	logic                last_s1, last_s2, last_s3;
	logic signed [CO_W:0]     dq_s2, dp_s2;
	logic signed [2*CO_W+1:0] mq_s3, mp_s3;
	logic [DW-1:0]       accq_q, accp_q, sum_q, sum_p, tq_s4, tp_s4;
	logic [KEY_W-1:0]    key;
	logic                elig;
	logic                found_q, more_q;
	logic [KEY_W-1:0]    best_q;
	logic [IW-1:0]       best_j_q;

	// output
	logic        out_free, do_emit;
	logic [31:0] cur_w, bj_w;

	assign full     = count_q == CW'(MAX_POINTS);
	assign load_acc = ctl.accept && (cmd == frnq_pkg::CMD_LOAD) && !full;
	assign pos_lt   = pos_q < PW'(DIM);
	assign pos_n    = pos_lt ? pos_q + PW'(1) : pos_q;
	assign finalize = (load_acc && coord_last && !(pos_n < PW'(DIM)))
		|| (ctl.fill && sts.fill_last);
	assign wsum     = base_q + BW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= frnq_pkg::RADIUS_RST;
			ref_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frnq_pkg::CFG_RADIUS: radius_q <= cfg_data;
				frnq_pkg::CFG_REF:    ref_q    <= cfg_data[frnq_pkg::REF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r2_q       <= radius_q * radius_q;
		piv_zero_q <= 32'(ref_q) >= 32'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			base_q  <= '0;
		end else if (finalize) begin
			count_q <= count_q + CW'(1);
			pos_q   <= '0;
			base_q  <= base_q + BW'(DIM);
		end else if (load_acc) begin
			pos_q <= pos_n;
		end else if (ctl.fill) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) lq_q <= is_query;
	end

	assign c_we    = (load_acc && pos_lt) || ctl.fill;
	assign c_waddr = wsum[AW-1:0];
	assign c_wdata = ctl.fill ? '0 : coord;
	assign f_we    = finalize;
	assign f_wdata = ctl.fill ? lq_q : is_query;

	assign pb = 32'(ref_q) * 32'(DIM) + 32'(ld_k_q);
	assign qb = 32'(cur_q) * 32'(DIM) + 32'(ld_k_q);

	always_comb begin
		if (ctl.issue_piv) begin
			c_raddr = pb[AW-1:0];
		end else if (ctl.issue_qry) begin
			c_raddr = qb[AW-1:0];
		end else begin
			c_raddr = sc_addr_q;
		end
	end

	frnq_ram #(.WIDTH(CO_W), .DEPTH(DEPTH)) u_coord_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	frnq_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_flag_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (count_q[IW-1:0]),
		.wdata (f_wdata),
		.raddr (cur_q[IW-1:0]),
		.rdata (f_rdata)
	);

	assign ld_last = ld_k_q == KW'(DIM - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_k_q <= '0;
			ldv_s1 <= 1'b0;
		end else begin
			ldv_s1 <= ctl.issue_piv || ctl.issue_qry;
			if (ctl.issue_piv || ctl.issue_qry) begin
				ld_k_q <= ld_last ? '0 : ld_k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ldt_s1 <= ctl.issue_qry;
		ldk_s1 <= ld_k_q;
		if (ldv_s1) begin
			if (ldt_s1) begin
				qc_q[ldk_s1] <= c_rdata;
			end else begin
				piv_q[ldk_s1] <= piv_zero_q ? '0 : c_rdata;
			end
		end
	end

	assign k_last    = sc_k_q == KW'(DIM - 1);
	assign scan_last = k_last && (32'(sc_j_q) == 32'(count_q) - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_addr_q <= '0;
			sc_j_q    <= '0;
			sc_k_q    <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			v_s1 <= ctl.scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && last_s3;
			if (ctl.scan_issue) begin
				sc_addr_q <= scan_last ? '0 : sc_addr_q + AW'(1);
				sc_k_q    <= k_last ? '0 : sc_k_q + KW'(1);
				if (k_last) begin
					sc_j_q <= scan_last ? '0 : sc_j_q + IW'(1);
				end
			end
		end
	end

	assign sum_q = (first_s3 ? '0 : accq_q) + DW'($unsigned(mq_s3));
	assign sum_p = (first_s3 ? '0 : accp_q) + DW'($unsigned(mp_s3));

	always_ff @(posedge clk) begin
		j_s1     <= sc_j_q;
		k_s1     <= sc_k_q;
		first_s1 <= sc_k_q == '0;
		last_s1  <= k_last;
		dq_s2    <= {qc_q[k_s1][CO_W-1], qc_q[k_s1]} - {c_rdata[CO_W-1], c_rdata};
		dp_s2    <= {piv_q[k_s1][CO_W-1], piv_q[k_s1]} - {c_rdata[CO_W-1], c_rdata};
		j_s2     <= j_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		mq_s3    <= dq_s2 * dq_s2;
		mp_s3    <= dp_s2 * dp_s2;
		j_s3     <= j_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		if (v_s3) begin
			accq_q <= sum_q;
			accp_q <= sum_p;
			tq_s4  <= sum_q;
			tp_s4  <= sum_p;
			j_s4   <= j_s3;
		end
	end

	assign key  = {tp_s4, j_s4};
	assign elig = v_s4 && (32'(j_s4) != 32'(cur_q)) && (tq_s4 <= DW'(r2_q))
		&& !(started_q && key <= prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			more_q  <= 1'b0;
		end else if (ctl.issue_qry) begin
			found_q <= 1'b0;
			more_q  <= 1'b0;
		end else if (elig) begin
			if (!found_q) begin
				found_q <= 1'b1;
				more_q  <= 1'b0;
			end else begin
				more_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (elig && (!found_q || key < best_q)) begin
			best_q   <= key;
			best_j_q <= j_s4;
		end
	end

	assign out_free = !out_valid || out_ready;
	assign do_emit  = (ctl.emit_res || ctl.emit_done) && out_free;
	assign cur_w    = 32'(cur_q);
	assign bj_w     = 32'(best_j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			prev_q    <= '0;
			started_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (do_emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (ctl.cur_inc) begin
				cur_q <= cur_q + CW'(1);
			end else if (ctl.emit_res && out_free) begin
				if (found_q && more_q) begin
					prev_q    <= best_q;
					started_q <= 1'b1;
				end else begin
					prev_q    <= '0;
					started_q <= 1'b0;
					cur_q     <= cur_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			if (ctl.emit_done) begin
				query_index    <= '0;
				neighbor_index <= '0;
				has_neighbor   <= 1'b0;
				last_of_query  <= 1'b0;
				all_done       <= 1'b1;
			end else begin
				query_index    <= cur_w[frnq_pkg::IDX_OUT_W-1:0];
				neighbor_index <= found_q ? bj_w[frnq_pkg::IDX_OUT_W-1:0] : '0;
				has_neighbor   <= found_q;
				last_of_query  <= !(found_q && more_q);
				all_done       <= 1'b0;
			end
		end
	end

	assign sts.is_fetch  = cmd == frnq_pkg::CMD_FETCH;
	assign sts.load_fill = (cmd == frnq_pkg::CMD_LOAD) && !full && coord_last
		&& (pos_n < PW'(DIM));
	assign sts.fill_last = pos_q == PW'(DIM - 1);
	assign sts.cur_end   = cur_q >= count_q;
	assign sts.flag      = f_rdata;
	assign sts.ld_last   = ld_last;
	assign sts.scan_last = scan_last;
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign sts.out_free  = out_free;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;

	localparam int NPTS = 40;
	localparam int ND = frnq_pkg::DIM_DEF;
	localparam longint LIMIT = 3000000;

	typedef logic signed [frnq_pkg::COORD_W-1:0] vec_t [ND];
	typedef struct {
		logic op;
		logic q;
		logic signed [frnq_pkg::COORD_W-1:0] c;
		logic last;
	} xfer_t;
	typedef struct {
		logic [frnq_pkg::IDX_OUT_W-1:0] qi;
		logic [frnq_pkg::IDX_OUT_W-1:0] ni;
		logic has;
		logic lastq;
		logic done;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [frnq_pkg::CFG_IDX_W-1:0] cfg_index = frnq_pkg::CFG_RADIUS;
	logic [frnq_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic cmd = frnq_pkg::CMD_LOAD;
	logic is_query = 0;
	logic signed [frnq_pkg::COORD_W-1:0] coord = '0;
	logic coord_last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [frnq_pkg::IDX_OUT_W-1:0] query_index;
	logic [frnq_pkg::IDX_OUT_W-1:0] neighbor_index;
	logic has_neighbor;
	logic last_of_query;
	logic all_done;

	fixed_radius_neighbor_query #(.MAX_POINTS(NPTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .is_query(is_query), .coord(coord), .coord_last(coord_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.query_index(query_index), .neighbor_index(neighbor_index),
		.has_neighbor(has_neighbor), .last_of_query(last_of_query), .all_done(all_done)
	);

	// neighbor search state mirrored from the block
	vec_t pts [NPTS];
	bit qflag [NPTS];
	int unsigned npts = 0;
	int unsigned cpos = 0;
	int unsigned curq = 0;
	logic [63:0] prev_key = '0;
	bit started = 0;
	logic [frnq_pkg::RADIUS_W-1:0] m_radius = frnq_pkg::RADIUS_RST;
	logic [frnq_pkg::REF_W-1:0] m_ref = '0;

	answer_t answers[$];
	xfer_t pending[$];
	xfer_t cur;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_go = 0;
	int hold_cnt = 0;
	int fails = 0;
	longint cycles = 0;

	function automatic logic [39:0] dist2(vec_t a, vec_t b);
		logic [39:0] s;
		longint d;
		s = '0;
		for (int k = 0; k < ND; k++) begin
			d = longint'(a[k]) - longint'(b[k]);
			s += 40'(d * d);
		end
		return s;
	endfunction

	function automatic void apply_transfer(xfer_t t);
		vec_t piv;
		vec_t qp;
		logic [63:0] r2;
		logic [63:0] key;
		logic [63:0] best;
		bit found;
		bit more;
		int unsigned bj;
		answer_t a;
		found = 0;
		more = 0;
		bj = 0;
		best = '0;
		if (t.op == frnq_pkg::CMD_LOAD) begin
			if (npts >= NPTS)
				return;
			if (cpos < ND) begin
				pts[npts][cpos] = t.c;
				cpos++;
			end
			if (t.last) begin
				for (int k = cpos; k < ND; k++)
					pts[npts][k] = '0;
				qflag[npts] = t.q;
				npts++;
				cpos = 0;
			end
			return;
		end
		while (curq < npts && !qflag[curq])
			curq++;
		a = '{default: 0};
		if (curq >= npts) begin
			a.done = 1;
			answers = {answers, a};
			return;
		end
		for (int k = 0; k < ND; k++)
			piv[k] = (m_ref < npts) ? pts[m_ref][k] : '0;
		qp = pts[curq];
		r2 = 64'(m_radius) * 64'(m_radius);
		for (int unsigned j = 0; j < npts; j++) begin
			if (j == curq || 64'(dist2(qp, pts[j])) > r2)
				continue;
			key = (64'(dist2(piv, pts[j])) << 12) | 64'(j);
			if (started && key <= prev_key)
				continue;
			if (!found) begin
				found = 1;
				best = key;
				bj = j;
				more = 0;
			end else begin
				if (key < best) begin
					best = key;
					bj = j;
				end
				more = 1;
			end
		end
		a.qi = curq[frnq_pkg::IDX_OUT_W-1:0];
		a.ni = found ? bj[frnq_pkg::IDX_OUT_W-1:0] : '0;
		a.has = found;
		a.lastq = !(found && more);
		if (found && more) begin
			prev_key = best;
			started = 1;
		end else begin
			prev_key = '0;
			started = 0;
			curq++;
		end
		answers = {answers, a};
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_transfer(cur);
			if (!in_valid || in_ready) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur = pending.pop_front();
					cmd <= cur.op;
					is_query <= cur.q;
					coord <= cur.c;
					coord_last <= cur.last;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_cnt <= 2000;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					$error("result transfer with nothing expected");
					fails++;
				end else begin
					e = answers.pop_front();
					if (query_index !== e.qi) begin
						$error("query_index expected %0d got %0d", e.qi, query_index);
						fails++;
					end
					if (neighbor_index !== e.ni) begin
						$error("neighbor_index expected %0d got %0d", e.ni, neighbor_index);
						fails++;
					end
					if (has_neighbor !== e.has) begin
						$error("has_neighbor expected %0d got %0d", e.has, has_neighbor);
						fails++;
					end
					if (last_of_query !== e.lastq) begin
						$error("last_of_query expected %0d got %0d", e.lastq, last_of_query);
						fails++;
					end
					if (all_done !== e.done) begin
						$error("all_done expected %0d got %0d", e.done, all_done);
						fails++;
					end
				end
			end
			if (hold_cnt > 0) begin
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic push_coord(logic signed [frnq_pkg::COORD_W-1:0] c, bit q, bit last);
		xfer_t t;
		t.op = frnq_pkg::CMD_LOAD;
		t.q = q;
		t.c = c;
		t.last = last;
		pending = {pending, t};
	endtask

	task automatic push_fetch();
		xfer_t t;
		t.op = frnq_pkg::CMD_FETCH;
		t.q = 1'($urandom_range(1));
		t.c = 16'($urandom);
		t.last = 1'($urandom_range(1));
		pending = {pending, t};
	endtask

	task automatic push_point(int n, bit q, int span, ref int cnt);
		int c;
		for (int k = 0; k < n; k++) begin
			c = (span == 0) ? int'($urandom) : int'($urandom_range(2 * span)) - span;
			push_coord(c[frnq_pkg::COORD_W-1:0], q, k == n - 1);
			cnt++;
		end
	endtask

	task automatic settle();
		while (pending.size() > 0 || in_valid || answers.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [frnq_pkg::CFG_IDX_W-1:0] idx,
		logic [frnq_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == frnq_pkg::CFG_RADIUS)
			m_radius = val[frnq_pkg::RADIUS_W-1:0];
		else
			m_ref = val[frnq_pkg::REF_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int cnt;
		int r;
		int spans [3] = '{0, 3000, 12000};
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// empty store, extremes, short and long points, ties, a partial point
		send_idle = 18;
		recv_idle = 59;
		push_fetch();
		for (int k = 0; k < ND; k++)
			push_coord('0, 1, k == ND - 1);
		push_coord(16'sd1000, 0, 1);
		for (int k = 0; k < 10; k++)
			push_coord(k == 8 ? 16'sh7fff : (k == 9 ? 16'sh8000 : 16'sd0), 1, k == 9);
		push_coord(16'sd1000, 0, 1);
		for (int k = 0; k < ND; k++)
			push_coord(16'sh7fff, 1, k == ND - 1);
		push_coord(16'sh8000, 0, 1);
		push_coord(16'sd200, 1, 0);
		push_coord(16'sd300, 1, 0);
		push_fetch();
		push_fetch();
		push_fetch();
		push_coord(16'sd400, 1, 1);
		repeat (5) push_fetch();
		settle();

		// wide radius with pivot not loaded, then close a started query
		write_cfg(frnq_pkg::CFG_RADIUS, 16'hffff);
		write_cfg(frnq_pkg::CFG_REF, 16'd1023);
		push_coord(16'sd0, 1, 1);
		repeat (3) push_fetch();
		settle();
		write_cfg(frnq_pkg::CFG_REF, 16'd2);
		push_coord(16'sd100, 1, 1);
		push_fetch();
		settle();
		write_cfg(frnq_pkg::CFG_RADIUS, 16'h0000);
		push_fetch();
		push_fetch();
		settle();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 18 : (ph == 1 ? 59 : 0);
			recv_idle = (ph == 0) ? 59 : (ph == 1 ? 18 : 0);
			r = $urandom_range(3);
			write_cfg(frnq_pkg::CFG_RADIUS,
				r == 0 ? 16'h0000 : (r == 1 ? 16'hffff : 16'($urandom)));
			write_cfg(frnq_pkg::CFG_REF, 16'($urandom_range(npts + 4)));
			cnt = 0;
			while (cnt < 10) begin
				r = $urandom_range(9);
				if (r < 3) begin
					push_fetch();
					cnt++;
				end else begin
					push_point(int'($urandom_range(1, 10)), 1'($urandom_range(1)),
						spans[$urandom_range(2)], cnt);
				end
			end
			if (ph == 0) begin
				repeat (3) push_fetch();
				hold_go = 1;
			end
			settle();
		end

		// fill the store to the top
		write_cfg(frnq_pkg::CFG_REF, 16'd1023);
		write_cfg(frnq_pkg::CFG_RADIUS, 16'hffff);
		cnt = 0;
		for (int i = int'(npts); i < NPTS + 2; i++)
			push_point(1, $urandom_range(19) == 0, 3000, cnt);
		repeat (3) push_fetch();
		settle();

		if (answers.size() > 0)
			fails++;
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/frnq_pkg.sv
rtl/core/frnq_ram.sv
rtl/core/frnq_ctrl.sv
rtl/core/frnq_dp.sv
rtl/core/fixed_radius_neighbor_query.sv
dv/tb.sv
